@@ rtl/core/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants, DFA table and byte classifier for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int WIDTH_W = 3;
   localparam int DFA_W   = 4;
   localparam int CLASS_W = 4;
   localparam int SEEN_W  = 2;

   localparam logic [DFA_W-1:0] DFA_ACCEPT   = 4'd0;
   localparam logic [DFA_W-1:0] DFA_REJECT   = 4'd1;
   localparam logic [DFA_W-1:0] DFA_LAST_ST  = 4'd8;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic              failed;
      logic [DFA_W-1:0]  dfa;
      logic [CP_W-1:0]   accum;
      logic [SEEN_W-1:0] seen;
   } u8d_state_type;

   typedef struct packed {
      logic [CP_W-1:0]    code_point;
      logic [WIDTH_W-1:0] byte_width;
      logic               status;
      logic               from_last;
   } u8d_result_type;

   // next state, indexed by {state, class}; states 0..8, classes 0..15
   localparam logic [DFA_W-1:0] NEXT_STATE [0:143] = '{
      4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
      4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
   };

   // character class of a byte, by range
   function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
      logic [CLASS_W-1:0] cls;
      priority if (b < 8'h80) cls = 4'd0;
      else if (b < 8'h90)     cls = 4'd1;
      else if (b < 8'hA0)     cls = 4'd9;
      else if (b < 8'hC0)     cls = 4'd7;
      else if (b < 8'hC2)     cls = 4'd8;
      else if (b < 8'hE0)     cls = 4'd2;
      else if (b == 8'hE0)    cls = 4'd10;
      else if (b == 8'hED)    cls = 4'd4;
      else if (b < 8'hF0)     cls = 4'd3;
      else if (b == 8'hF0)    cls = 4'd11;
      else if (b < 8'hF4)     cls = 4'd6;
      else if (b == 8'hF4)    cls = 4'd5;
      else                    cls = 4'd8;
      return cls;
   endfunction

endpackage

@@ rtl/core/u8d_step.sv @@
// ----------------------------------------------------------------------------
// u8d_step
// One DFA step: classifies a byte, advances the state, builds the code
// point and decides whether a result goes out.
// ----------------------------------------------------------------------------
module u8d_step (
   input  u8d_pkg::u8d_state_type          state_cur,
   input  logic [u8d_pkg::BYTE_W-1:0]      in_byte,
   input  logic                            in_last,
   output u8d_pkg::u8d_state_type          state_nxt,
   output logic                            emit,
   output u8d_pkg::u8d_result_type         result
);

   logic [u8d_pkg::CLASS_W-1:0] cls;
   logic [u8d_pkg::DFA_W-1:0]   st_eff;
   logic [u8d_pkg::DFA_W-1:0]   st_new;
   logic [u8d_pkg::CP_W-1:0]    accum_new;
   logic [u8d_pkg::BYTE_W-1:0]  lead_mask;
   logic [7:0]                  tbl_idx;
   logic [u8d_pkg::WIDTH_W-1:0] width;

   always_comb begin
      cls       = u8d_pkg::byte_class(in_byte);
      st_eff    = (state_cur.dfa > u8d_pkg::DFA_LAST_ST) ? u8d_pkg::DFA_REJECT
                                                        : state_cur.dfa;
      lead_mask = 8'hFF >> cls;
      if (st_eff != u8d_pkg::DFA_ACCEPT) begin
         accum_new = {state_cur.accum[u8d_pkg::CP_W-7:0], in_byte[5:0]};
      end else begin
         accum_new = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, lead_mask & in_byte};
      end
      tbl_idx = {st_eff, cls};
      st_new  = u8d_pkg::NEXT_STATE[tbl_idx];
      width   = {1'b0, state_cur.seen} + 3'd1;

      emit      = 1'b0;
      result    = '0;
      state_nxt = state_cur;
      result.from_last = in_last;

      if (!state_cur.failed) begin
         if (st_new == u8d_pkg::DFA_REJECT) begin
            emit          = 1'b1;
            result.status = u8d_pkg::STATUS_INVALID;
            state_nxt     = '0;
            state_nxt.failed = 1'b1;
         end else if (st_new == u8d_pkg::DFA_ACCEPT) begin
            emit              = 1'b1;
            result.code_point = accum_new;
            result.byte_width = width;
            result.status     = u8d_pkg::STATUS_OK;
            state_nxt         = '0;
         end else begin
            state_nxt.dfa   = st_new;
            state_nxt.accum = accum_new;
            state_nxt.seen  = state_cur.seen + 2'd1;
         end
      end

      // end of string: drop any open sequence and the failed mark
      if (in_last) begin
         state_nxt = '0;
      end
   end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Validating UTF-8 decoder: one byte in, at most one code point or error out.
// ----------------------------------------------------------------------------
// Takes one byte per transfer on req_ and accepts a new byte every cycle
// while rsp_ is not stalled; each result passes from its byte through the
// input register, then the result register; the sustained rate of one byte per
// cycle is set by the single DFA step between those registers. A result goes
// out when a sequence completes (code point plus width 1..4) or on the first
// invalid byte of a string (tuser high, data zero); later bytes of a rejected
// string give nothing. req_tlast closes a string and clears all decode state;
// an unfinished sequence at that point is dropped without a result.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // string_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] byte_width
   output logic        rsp_tuser,   // status
   output logic        rsp_tlast    // from_last_byte
);

   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [u8d_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                            in_last_ff;
   u8d_pkg::u8d_state_type          state_ff;
   u8d_pkg::u8d_state_type          state_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   u8d_pkg::u8d_result_type         rsp_ff;
   u8d_pkg::u8d_result_type         step_result;
   logic                            step_emit;
   logic                            out_free;
   logic                            step_fire;
   logic                            req_fire;

   u8d_step u_step (
      .state_cur (state_ff),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .state_nxt (state_in),
      .emit      (step_emit),
      .result    (step_result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_fire  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || step_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (step_fire) begin
         rsp_valid_in = step_emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step_fire && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.byte_width, rsp_ff.code_point};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.from_last;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == u8d_pkg::STATUS_INVALID
      |-> rsp_ff.code_point == '0 && rsp_ff.byte_width == '0)
      else $error("error transfer carries nonzero data");

   a_ok_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == u8d_pkg::STATUS_OK
      |-> rsp_ff.byte_width != 3'd0 && rsp_ff.byte_width <= 3'd4)
      else $error("decoded width out of range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_last_ff |=> state_ff == '0)
      else $error("state not cleared after last byte");

   a_failed_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.failed |-> state_ff.dfa == u8d_pkg::DFA_ACCEPT && state_ff.seen == '0)
      else $error("rejected string left an open sequence");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
// Byte strings are queued by the stimulus process and driven on req_ by a
// clocked driver. Every accepted byte runs through a local DFA decoder that
// queues the expected code point or error. A clocked monitor compares each
// rsp_ transfer against the oldest queued expectation. Both sides idle at
// phase-dependent rates; a long receiver hold-off and drain pauses add
// pressure.
module tb_top;

   localparam int HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   // next DFA state, one nibble per byte class (class 0 in bits 3:0)
   localparam logic [63:0] DFA_ROWS [0:8] = '{
      64'h1111_6411_1785_3210,
      64'h1111_1111_1111_1111,
      64'h1111_1101_0111_1101,
      64'h1111_1121_2111_1121,
      64'h1111_1111_2111_1111,
      64'h1111_1121_1111_1121,
      64'h1111_1131_3111_1111,
      64'h1111_1131_3111_1131,
      64'h1111_1111_1111_1131
   };

   localparam int unsigned CP_LO [0:3] = '{32'h0, 32'h80, 32'h800, 32'h10000};
   localparam int unsigned CP_HI [0:3] = '{32'h7F, 32'h7FF, 32'hFFFF, 32'h10FFFF};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   byte_item_type           tx_bytes[$];
   logic [7:0]              str_bytes[$];
   u8d_pkg::u8d_result_type expected_chars[$];
   u8d_pkg::u8d_result_type want_char;

   // local decoder state
   logic [3:0]  dec_state = u8d_pkg::DFA_ACCEPT;
   logic [20:0] dec_accum = '0;
   logic [1:0]  dec_count = '0;
   logic        dec_failed = 1'b0;

   bit offer_open = 1'b0;
   bit hold_go = 1'b0;
   int hold_left = 0;
   int send_idle = 19;
   int recv_idle = 83;
   int mismatch_count = 0;
   int results_seen = 0;
   int cycle_count = 0;

   utf8_stream_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [3:0] char_class(input logic [7:0] b);
      logic [3:0] cls;
      if (!b[7]) begin
         cls = 4'd0;
      end else begin
         case (b[7:4])
            4'h8: cls = 4'd1;
            4'h9: cls = 4'd9;
            4'hA, 4'hB: cls = 4'd7;
            4'hC: cls = (b[3:1] == 3'd0) ? 4'd8 : 4'd2;  // C0/C1 are overlong leads
            4'hD: cls = 4'd2;
            4'hE: cls = (b == 8'hE0) ? 4'd10 : (b == 8'hED) ? 4'd4 : 4'd3;
            default: begin
               if (b == 8'hF0)      cls = 4'd11;
               else if (b < 8'hF4)  cls = 4'd6;
               else if (b == 8'hF4) cls = 4'd5;
               else                 cls = 4'd8;
            end
         endcase
      end
      return cls;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [3:0] cls;
      logic [3:0] nxt;
      u8d_pkg::u8d_result_type res;
      if (!dec_failed) begin
         cls = char_class(b);
         if (dec_state != u8d_pkg::DFA_ACCEPT) dec_accum = {dec_accum[14:0], b[5:0]};
         else dec_accum = {13'd0, b & (8'hFF >> cls)};
         nxt = DFA_ROWS[dec_state][{cls, 2'b00} +: 4];
         if (nxt == u8d_pkg::DFA_REJECT) begin
            res.code_point = '0;
            res.byte_width = '0;
            res.status = u8d_pkg::STATUS_INVALID;
            res.from_last = last;
            expected_chars.push_back(res);
            dec_state = u8d_pkg::DFA_ACCEPT;
            dec_accum = '0;
            dec_count = '0;
            dec_failed = 1'b1;
         end else if (nxt == u8d_pkg::DFA_ACCEPT) begin
            res.code_point = dec_accum;
            res.byte_width = {1'b0, dec_count} + 3'd1;
            res.status = u8d_pkg::STATUS_OK;
            res.from_last = last;
            expected_chars.push_back(res);
            dec_state = u8d_pkg::DFA_ACCEPT;
            dec_accum = '0;
            dec_count = '0;
         end else begin
            dec_state = nxt;
            dec_count = dec_count + 2'd1;
         end
      end
      if (last) begin
         dec_state = u8d_pkg::DFA_ACCEPT;
         dec_accum = '0;
         dec_count = '0;
         dec_failed = 1'b0;
      end
   endtask

   task automatic append_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         str_bytes.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         str_bytes.push_back({3'b110, cp[10:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         str_bytes.push_back({4'b1110, cp[15:12]});
         str_bytes.push_back({2'b10, cp[11:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end else begin
         str_bytes.push_back({5'b11110, cp[20:18]});
         str_bytes.push_back({2'b10, cp[17:12]});
         str_bytes.push_back({2'b10, cp[11:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end
   endtask

   function automatic logic [20:0] pick_code_point();
      int unsigned k;
      logic [20:0] cp;
      k = $urandom_range(0, 3);
      cp = 21'($urandom_range(CP_LO[k], CP_HI[k]));
      if ($urandom_range(0, 7) == 0) cp = $urandom_range(0, 1) ? 21'(CP_LO[k]) : 21'(CP_HI[k]);
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h8000;
      return cp;
   endfunction

   // move the assembled string to the driver queue, tlast on its final byte
   task automatic send_string();
      for (int i = 0; i < str_bytes.size(); i++)
         tx_bytes.push_back('{data: str_bytes[i], last: (i == str_bytes.size() - 1)});
      str_bytes.delete();
   endtask

   task automatic queue_random_strings(input int byte_target);
      int queued;
      int pick;
      int pos;
      queued = 0;
      while (queued < byte_target) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) append_code_point(pick_code_point());
            if (pick >= 70 && pick < 78) begin
               pos = $urandom_range(0, str_bytes.size() - 1);
               str_bytes[pos] = 8'($urandom);
            end else if (pick >= 78 && pick < 86) begin
               // string ends inside a multi-byte character
               append_code_point(21'($urandom_range(32'h80, 32'h10FFFF)));
               void'(str_bytes.pop_back());
            end else if (pick >= 86) begin
               case ($urandom_range(0, 6))
                  0: str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 1)));
                  1: begin
                     str_bytes.push_back(8'hED);
                     str_bytes.push_back(8'($urandom_range(32'hA0, 32'hBF)));
                  end
                  2: begin
                     str_bytes.push_back(8'hE0);
                     str_bytes.push_back(8'($urandom_range(32'h80, 32'h9F)));
                  end
                  3: begin
                     str_bytes.push_back(8'hF0);
                     str_bytes.push_back(8'($urandom_range(32'h80, 32'h8F)));
                  end
                  4: begin
                     str_bytes.push_back(8'hF4);
                     str_bytes.push_back(8'($urandom_range(32'h90, 32'hBF)));
                  end
                  5: str_bytes.push_back(8'($urandom_range(32'hF5, 32'hFF)));
                  default: str_bytes.push_back(8'($urandom_range(32'h80, 32'hBF)));
               endcase
               repeat ($urandom_range(0, 2)) append_code_point(pick_code_point());
            end
         end
         queued += str_bytes.size();
         send_string();
      end
   endtask

   task automatic wait_drained();
      while (tx_bytes.size() != 0 || offer_open || expected_chars.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (!offer_open) begin
         if (!reset && tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req_tvalid <= 1'b1;
            req_tdata <= tx_bytes[0].data;
            req_tlast <= tx_bytes[0].last;
            offer_open = 1'b1;
         end else begin
            req_tvalid <= 1'b0;
            req_tdata <= 8'($urandom);
            req_tlast <= 1'($urandom);
         end
      end
   end

   // request transfer: run the byte through the local decoder
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         decode_byte(tx_bytes[0].data, tx_bytes[0].last);
         void'(tx_bytes.pop_front());
         offer_open = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (hold_go) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(negedge clock)
      rsp_tready <= !hold_go && hold_left == 0 && $urandom_range(0, 99) >= recv_idle;

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("result %0d: none expected, got cp=%h width=%0d status=%0b last=%0b",
                        results_seen, rsp_tdata[20:0], rsp_tdata[23:21], rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want_char = expected_chars.pop_front();
            if (want_char.code_point !== rsp_tdata[20:0] ||
                want_char.byte_width !== rsp_tdata[23:21] ||
                want_char.status !== rsp_tuser || want_char.from_last !== rsp_tlast) begin
               if (mismatch_count < MAX_REPORTS)
                  $display({"result %0d: expected cp=%h width=%0d status=%0b last=%0b,",
                            " got cp=%h width=%0d status=%0b last=%0b"}, results_seen,
                           want_char.code_point, want_char.byte_width, want_char.status,
                           want_char.from_last, rsp_tdata[20:0], rsp_tdata[23:21],
                           rsp_tuser, rsp_tlast);
               mismatch_count++;
            end
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // each width at both ends of its range, in one string
      append_code_point(21'h0);
      append_code_point(21'h7F);
      append_code_point(21'h80);
      append_code_point(21'h7FF);
      append_code_point(21'h800);
      append_code_point(21'hFFFF);
      append_code_point(21'h10000);
      append_code_point(21'h10FFFF);
      send_string();
      // lone continuation byte rejects; the rest of the string is ignored
      str_bytes = '{8'h80, 8'hFF, 8'h41};
      send_string();
      // unfinished sequence at end of string is dropped
      str_bytes = '{8'hE2, 8'h82};
      send_string();

      queue_random_strings(170);
      wait_drained();

      send_idle = 83;
      recv_idle = 19;
      queue_random_strings(170);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      queue_random_strings(190);
      // long receiver hold-off while the sender keeps offering
      repeat (30) @(posedge clock);
      hold_go = 1'b1;
      @(posedge clock);
      hold_go = 1'b0;
      wait_drained();

      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
